FILE: sv/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

   localparam int SLOT_W    = 6;
   localparam int WORD_W    = 32;
   localparam int SIZE_W    = 31;
   localparam int LIFE_W    = 17;
   localparam int DECAY_W   = 16;
   localparam int OP_W      = 2;
   localparam int KIND_W    = 2;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 136;

   localparam logic [LIFE_W-1:0]  LIFE_ONE    = 17'd32768;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd328;

   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADD_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LIVE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

   // Word of the position memory: written by add and by tick.
   typedef struct packed {
      logic [LIFE_W-1:0] life;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_x;
   } pos_word_type;

   // Word of the attribute memory: written by add only.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [WORD_W-1:0] rgba;
      logic [WORD_W-1:0] vel_y;
      logic [WORD_W-1:0] vel_x;
   } att_word_type;

   typedef struct packed {
      logic              live;
      logic [LIFE_W-1:0] life;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_x;
   } alu_out_type;

endpackage

FILE: sv/ppe_ram.sv
`timescale 1ns / 1ps

module ppe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ppe_alu.sv
`timescale 1ns / 1ps

module ppe_alu
   import ppe_pkg::*;
(
   input  logic                 entry_valid,
   input  pos_word_type         pos_word,
   input  logic [WORD_W-1:0]    vel_x,
   input  logic [WORD_W-1:0]    vel_y,
   input  logic [DECAY_W-1:0]   decay,
   output alu_out_type          result
);

   logic [LIFE_W-1:0] life_now;

   // An entry never written reads as a free slot with zero life.
   assign life_now = entry_valid ? pos_word.life : '0;

   always_comb begin
      result.live  = ($signed(life_now) > $signed({LIFE_W{1'b0}}));
      result.life  = life_now - {{(LIFE_W - DECAY_W){1'b0}}, decay};
      result.pos_x = pos_word.pos_x + vel_x;
      result.pos_y = pos_word.pos_y + vel_y;
   end

endmodule

FILE: sv/particle_pool_engine.sv
`timescale 1ns / 1ps
// Add runs a free-slot search first, checking one slot per cycle.
// Add and draw wait out output stalls.
// All three walk the pool through one read address shared by both memories and one shared slot unit,
// so one item is in work at a time and ready is low meanwhile.
// Reset marks every slot free, clears next_free and loads decay_rate with 328.
module particle_pool_engine
   import ppe_pkg::*;
#(
   parameter int POOL_SIZE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Fields from bit 0: pos_x, pos_y, vel_x, vel_y, rgba, size, zero pad.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: opcode.
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: slot, out_pos_x, out_pos_y, out_size, out_rgba, zero pad.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: kind.
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [DECAY_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(POOL_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_ADD    = 3'd2;
   localparam logic [2:0] S_TICK   = 3'd3;
   localparam logic [2:0] S_DRAW   = 3'd4;
   localparam logic [2:0] S_FLUSH  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     nf_ff, nf_in;
   logic [DECAY_W-1:0]   decay_ff;
   logic [POOL_SIZE-1:0] valid_ff, valid_in;
   pos_word_type         new_pos_ff, new_pos_in;
   att_word_type         new_att_ff, new_att_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [WORD_W-1:0]    pend_px_ff, pend_px_in;
   logic [WORD_W-1:0]    pend_py_ff, pend_py_in;
   logic [SIZE_W-1:0]    pend_size_ff, pend_size_in;
   logic [WORD_W-1:0]    pend_rgba_ff, pend_rgba_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [WORD_W-1:0]    rsp_px_ff, rsp_px_in;
   logic [WORD_W-1:0]    rsp_py_ff, rsp_py_in;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic [WORD_W-1:0]    rsp_rgba_ff, rsp_rgba_in;

   logic                 pos_we, att_we;
   pos_word_type         pos_wdata, pos_rdata;
   att_word_type         att_rdata;
   alu_out_type          alu;
   logic                 out_free;
   logic [IDX_W-1:0]     idx_next;

   ppe_ram #(
      .WIDTH ($bits(pos_word_type)),
      .DEPTH (POOL_SIZE)
   ) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (idx_ff),
      .wdata (pos_wdata),
      .raddr (idx_in),
      .rdata (pos_rdata)
   );

   ppe_ram #(
      .WIDTH ($bits(att_word_type)),
      .DEPTH (POOL_SIZE)
   ) u_att_ram (
      .clock (clock),
      .we    (att_we),
      .waddr (idx_ff),
      .wdata (new_att_ff),
      .raddr (idx_in),
      .rdata (att_rdata)
   );

   ppe_alu u_alu (
      .entry_valid (valid_ff[idx_ff]),
      .pos_word    (pos_rdata),
      .vel_x       (att_rdata.vel_x),
      .vel_y       (att_rdata.vel_y),
      .decay       (decay_ff),
      .result      (alu)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      nf_in         = nf_ff;
      valid_in      = valid_ff;
      new_pos_in    = new_pos_ff;
      new_att_in    = new_att_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_px_in    = pend_px_ff;
      pend_py_in    = pend_py_ff;
      pend_size_in  = pend_size_ff;
      pend_rgba_in  = pend_rgba_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_px_in     = rsp_px_ff;
      rsp_py_in     = rsp_py_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_rgba_in   = rsp_rgba_ff;
      pos_we        = 1'b0;
      att_we        = 1'b0;
      pos_wdata     = new_pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               new_pos_in.pos_x = req_tdata[31:0];
               new_pos_in.pos_y = req_tdata[63:32];
               new_pos_in.life  = LIFE_ONE;
               new_att_in.vel_x = req_tdata[95:64];
               new_att_in.vel_y = req_tdata[127:96];
               new_att_in.rgba  = req_tdata[159:128];
               new_att_in.size  = req_tdata[190:160];
               cnt_in           = '0;
               pend_valid_in    = 1'b0;
               unique case (req_tuser)
                  OP_ADD: begin
                     idx_in   = nf_ff;
                     state_in = S_SEARCH;
                  end
                  OP_TICK: begin
                     idx_in   = '0;
                     state_in = S_TICK;
                  end
                  OP_DRAW: begin
                     idx_in   = '0;
                     state_in = S_DRAW;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (!alu.live) begin
               nf_in    = idx_ff;
               state_in = S_ADD;
            end else if (cnt_ff == LAST_IDX) begin
               // Every slot is live: the new particle replaces slot 0.
               idx_in   = '0;
               state_in = S_ADD;
            end else begin
               idx_in = idx_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ADD: begin
            if (out_free) begin
               pos_we           = 1'b1;
               att_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_ADD_ACK;
               rsp_last_in      = 1'b1;
               rsp_slot_in      = SLOT_W'(idx_ff);
               rsp_px_in        = new_pos_ff.pos_x;
               rsp_py_in        = new_pos_ff.pos_y;
               rsp_size_in      = new_att_ff.size;
               rsp_rgba_in      = new_att_ff.rgba;
               state_in         = S_IDLE;
            end
         end
         S_TICK: begin
            if (alu.live) begin
               pos_we          = 1'b1;
               pos_wdata.pos_x = alu.pos_x;
               pos_wdata.pos_y = alu.pos_y;
               pos_wdata.life  = alu.life;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_DRAW: begin
            // A live slot is held in pend until the next live one, so the final one can carry last.
            if (!(alu.live && pend_valid_ff && !out_free)) begin
               if (alu.live) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_LIVE;
                     rsp_last_in  = 1'b0;
                     rsp_slot_in  = SLOT_W'(pend_slot_ff);
                     rsp_px_in    = pend_px_ff;
                     rsp_py_in    = pend_py_ff;
                     rsp_size_in  = pend_size_ff;
                     rsp_rgba_in  = pend_rgba_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_ff;
                  pend_px_in    = pos_rdata.pos_x;
                  pend_py_in    = pos_rdata.pos_y;
                  pend_size_in  = att_rdata.size;
                  pend_rgba_in  = att_rdata.rgba;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in = KIND_LIVE;
                  rsp_slot_in = SLOT_W'(pend_slot_ff);
                  rsp_px_in   = pend_px_ff;
                  rsp_py_in   = pend_py_ff;
                  rsp_size_in = pend_size_ff;
                  rsp_rgba_in = pend_rgba_ff;
               end else begin
                  rsp_kind_in = KIND_NONE;
                  rsp_slot_in = '0;
                  rsp_px_in   = '0;
                  rsp_py_in   = '0;
                  rsp_size_in = '0;
                  rsp_rgba_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         nf_ff         <= '0;
         decay_ff      <= DECAY_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         nf_ff         <= nf_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            decay_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      new_pos_ff   <= new_pos_in;
      new_att_ff   <= new_att_in;
      pend_slot_ff <= pend_slot_in;
      pend_px_ff   <= pend_px_in;
      pend_py_ff   <= pend_py_in;
      pend_size_ff <= pend_size_in;
      pend_rgba_ff <= pend_rgba_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_rgba_ff  <= rsp_rgba_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_rgba_ff, rsp_size_ff, rsp_py_ff, rsp_px_ff, rsp_slot_ff};

endmodule
